[rtl/bc1_block_decoder_defines.svh]
// ----------------------------------------------------------------------------
// BC1 block decoder assertion macros
// Shared concurrent assertion forms, clocked by clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BC1_BLOCK_DECODER_DEFINES_SVH
`define BC1_BLOCK_DECODER_DEFINES_SVH

// Same-cycle implication, clocked by clk_i, off while rst_ni is low.
`define BC1_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked by clk_i, off while rst_ni is low.
`define BC1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bc1_pkg.sv]
// ----------------------------------------------------------------------------
// BC1 decoder package
// Shared types, constants and channel expansion helpers.
// ----------------------------------------------------------------------------
package bc1_pkg;

  localparam int unsigned PixelsPerBlock = 16;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // Expansion v*255/31 and v*255/63 as a multiply by a rounded-up reciprocal.
  localparam int unsigned ExpShift = 20;
  localparam logic [27:0] Exp5Mul  = 28'd8625630;  // 255 * ceil(2^20 / 31)
  localparam logic [27:0] Exp6Mul  = 28'd4244475;  // 255 * ceil(2^20 / 63)

  // Division by three of values below 1024: x * 683 >> 11.
  localparam int unsigned ThirdShift = 11;
  localparam logic [20:0] ThirdMul   = 21'd683;

  // One palette set and its index word, as moved from front to back.
  typedef struct packed {
    logic [3:0][31:0] pal;
    logic [31:0]      idx;
  } bc1_entry_t;

  // Queue status seen by the back end and the top level.
  typedef struct packed {
    logic full;
    logic head_valid;
  } bc1_qstat_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [27:0] prod;
    prod = 28'(v) * Exp5Mul;
    return prod[ExpShift +: 8];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [27:0] prod;
    prod = 28'(v) * Exp6Mul;
    return prod[ExpShift +: 8];
  endfunction

  function automatic logic [7:0] third(input logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * ThirdMul;
    return prod[ThirdShift +: 8];
  endfunction

endpackage

[rtl/bc1_front.sv]
// ----------------------------------------------------------------------------
// BC1 front end
// Accepts blocks, expands the endpoints and builds the four-entry palette.
// ----------------------------------------------------------------------------
module bc1_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [63:0]         block_bits_i,
  input  logic                block_valid_i,
  output logic                block_ready_o,
  output logic                push_valid_o,
  output bc1_pkg::bc1_entry_t push_entry_o,
  input  logic                push_ready_i
);
  import bc1_pkg::*;

  typedef struct packed {
    logic        four_color;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
    logic [31:0] idx;
  } stage_t;

  logic   st_valid_q, st_valid_d;
  stage_t st_q, st_d;
  logic   accept;

  logic [15:0] c0, c1;
  assign c0 = block_bits_i[15:0];
  assign c1 = block_bits_i[31:16];

  assign block_ready_o = !st_valid_q || push_ready_i;
  assign accept        = block_valid_i && block_ready_o;

  always_comb begin
    st_d.four_color = (c0 > c1);
    st_d.r0  = expand5(c0[15:11]);
    st_d.g0  = expand6(c0[10:5]);
    st_d.b0  = expand5(c0[4:0]);
    st_d.r1  = expand5(c1[15:11]);
    st_d.g1  = expand6(c1[10:5]);
    st_d.b1  = expand5(c1[4:0]);
    st_d.idx = block_bits_i[63:32];
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = 1'b1;
    end else if (push_ready_i) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= st_d;
    end
  end

  // Palette: endpoints, then thirds or midpoint plus transparent black.
  logic [9:0] r_a2b, g_a2b, b_a2b, r_ab2, g_ab2, b_ab2;
  logic [8:0] r_sum, g_sum, b_sum;

  always_comb begin
    r_a2b = {1'b0, st_q.r0, 1'b0} + 10'(st_q.r1);
    g_a2b = {1'b0, st_q.g0, 1'b0} + 10'(st_q.g1);
    b_a2b = {1'b0, st_q.b0, 1'b0} + 10'(st_q.b1);
    r_ab2 = 10'(st_q.r0) + {1'b0, st_q.r1, 1'b0};
    g_ab2 = 10'(st_q.g0) + {1'b0, st_q.g1, 1'b0};
    b_ab2 = 10'(st_q.b0) + {1'b0, st_q.b1, 1'b0};
    r_sum = 9'(st_q.r0) + 9'(st_q.r1);
    g_sum = 9'(st_q.g0) + 9'(st_q.g1);
    b_sum = 9'(st_q.b0) + 9'(st_q.b1);

    push_entry_o.idx    = st_q.idx;
    push_entry_o.pal[0] = {AlphaOpaque, st_q.r0, st_q.g0, st_q.b0};
    push_entry_o.pal[1] = {AlphaOpaque, st_q.r1, st_q.g1, st_q.b1};
    if (st_q.four_color) begin
      push_entry_o.pal[2] = {AlphaOpaque, third(r_a2b), third(g_a2b), third(b_a2b)};
      push_entry_o.pal[3] = {AlphaOpaque, third(r_ab2), third(g_ab2), third(b_ab2)};
    end else begin
      push_entry_o.pal[2] = {AlphaOpaque, r_sum[8:1], g_sum[8:1], b_sum[8:1]};
      push_entry_o.pal[3] = 32'h0000_0000;
    end
  end

  assign push_valid_o = st_valid_q;

endmodule

[rtl/bc1_queue.sv]
// ----------------------------------------------------------------------------
// BC1 palette queue
// Small FIFO of decoded palettes between the front and back ends.
// ----------------------------------------------------------------------------
module bc1_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  bc1_pkg::bc1_entry_t push_entry_i,
  output logic                push_ready_o,
  input  logic                pop_i,
  output bc1_pkg::bc1_entry_t head_entry_o,
  output bc1_pkg::bc1_qstat_t stat_o
);
  import bc1_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  bc1_entry_t mem [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign stat_o.full       = (count_q == CntW'(Depth));
  assign stat_o.head_valid = (count_q != '0);
  assign push_ready_o      = !stat_o.full;
  assign push              = push_valid_i && !stat_o.full;
  assign pop               = pop_i && stat_o.head_valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_entry_i;
    end
  end

  assign head_entry_o = mem[rd_ptr_q];

endmodule

[rtl/bc1_back.sv]
// ----------------------------------------------------------------------------
// BC1 back end
// Walks the sixteen pixels of the head palette into a registered output.
// ----------------------------------------------------------------------------
module bc1_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bc1_pkg::bc1_entry_t head_entry_i,
  input  bc1_pkg::bc1_qstat_t qstat_i,
  output logic                pop_o,
  output logic                pixel_valid_o,
  input  logic                pixel_ready_i,
  output logic [31:0]         pixel_argb_o,
  output logic [1:0]          pixel_column_o,
  output logic [1:0]          pixel_row_o,
  output logic                last_of_block_o
);
  import bc1_pkg::*;

  localparam int unsigned PixW = $clog2(PixelsPerBlock);

  logic [PixW-1:0] pix_q, pix_d;
  logic            out_valid_q, out_valid_d;
  logic            load, is_last;
  logic [1:0]      sel;

  assign load    = qstat_i.head_valid && (!out_valid_q || pixel_ready_i);
  assign is_last = (pix_q == PixW'(PixelsPerBlock - 1));
  assign pop_o   = load && is_last;
  assign sel     = head_entry_i.idx[{pix_q, 1'b0} +: 2];

  always_comb begin
    pix_d       = pix_q;
    out_valid_d = out_valid_q;
    if (load) begin
      pix_d       = pix_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (pixel_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pix_q       <= pix_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_argb_o    <= head_entry_i.pal[sel];
      pixel_column_o  <= pix_q[1:0];
      pixel_row_o     <= pix_q[3:2];
      last_of_block_o <= is_last;
    end
  end

  assign pixel_valid_o = out_valid_q;

endmodule

[rtl/bc1_block_decoder.sv]
// ----------------------------------------------------------------------------
// BC1 block decoder
// Decompresses 64-bit BC1 texture blocks into sixteen ARGB pixels each.
// ----------------------------------------------------------------------------
// A block transaction carries two RGB565 endpoints and sixteen 2-bit indices;
// the block answers with sixteen pixel transactions in row-major order, each
// with its column and row, the sixteenth marked by last_of_block_o. The pixel
// port delivers one pixel per cycle while the consumer is ready, a rate set
// by the single output register in the back end. A block is registered in
// the front stage on acceptance, its palette is then written into the queue,
// and its first pixel is loaded into the back end's output register once that
// palette heads the queue; a full queue or a stalled consumer can hold either
// step. The queue of QueueDepth palettes lets new blocks be taken while
// earlier pixels are still being delivered or held by a stalled consumer.
`include "bc1_block_decoder_defines.svh"

module bc1_block_decoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] block_bits_i,
  input  logic        block_valid_i,
  output logic        block_ready_o,
  output logic        pixel_valid_o,
  input  logic        pixel_ready_i,
  output logic [31:0] pixel_argb_o,
  output logic [1:0]  pixel_column_o,
  output logic [1:0]  pixel_row_o,
  output logic        last_of_block_o
);
  import bc1_pkg::*;

  // Front to queue: one palette set per block.
  logic       push_valid, push_ready, pop;
  bc1_entry_t push_entry, head_entry;
  bc1_qstat_t qstat;

  // The front end expands endpoints and interpolates the palette.
  bc1_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .block_bits_i  (block_bits_i),
    .block_valid_i (block_valid_i),
    .block_ready_o (block_ready_o),
    .push_valid_o  (push_valid),
    .push_entry_o  (push_entry),
    .push_ready_i  (push_ready)
  );

  // The queue decouples palette building from pixel delivery.
  bc1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_entry_o (head_entry),
    .stat_o       (qstat)
  );

  // The back end walks the indices and pops the palette after pixel fifteen.
  bc1_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_entry_i    (head_entry),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .pixel_valid_o   (pixel_valid_o),
    .pixel_ready_i   (pixel_ready_i),
    .pixel_argb_o    (pixel_argb_o),
    .pixel_column_o  (pixel_column_o),
    .pixel_row_o     (pixel_row_o),
    .last_of_block_o (last_of_block_o)
  );

  // The last pixel of a block always sits in the bottom-right corner.
  `BC1_ASSERT_IMPL(a_last_corner, pixel_valid_o && last_of_block_o,
                   pixel_column_o == 2'd3 && pixel_row_o == 2'd3,
                   "last pixel is not at column 3, row 3")

  // Only the transparent palette entry has a non-opaque alpha, and it is zero.
  `BC1_ASSERT_IMPL(a_alpha_form, pixel_valid_o && pixel_argb_o[31:24] != AlphaOpaque,
                   pixel_argb_o == 32'h0000_0000,
                   "non-opaque pixel is not transparent black")

  // With a palette waiting and the consumer ready, pixels follow each other without gaps.
  `BC1_ASSERT_NEXT(a_no_bubble, pixel_valid_o && pixel_ready_i && qstat.head_valid,
                   pixel_valid_o,
                   "pixel output idled while a palette was queued")

  // A palette is popped only at the end of its sixteen pixels.
  `BC1_ASSERT_NEXT(a_pop_last, pop, last_of_block_o && pixel_valid_o,
                   "palette popped without emitting the last pixel")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// BC1 block decoder testbench
// Feeds directed and random BC1 blocks into the decoder and checks every
// pixel transaction against a palette decode computed in the testbench.
// ----------------------------------------------------------------------------
// Both channels use valid/ready. The sender and the receiver each wait a
// random pause before every transaction, with stretches of no idling
// on either side. Every accepted block adds sixteen expected pixels to an
// in-order queue. Every accepted pixel is compared field by field with the
// oldest expected pixel.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import bc1_pkg::PixelsPerBlock;

  // One expected or observed pixel transaction.
  typedef struct {
    logic [31:0] argb;
    logic [1:0]  column;
    logic [1:0]  row;
    logic        last;
  } pixel_t;

  // Keeps the pixels that the accepted blocks must still produce, in order,
  // and checks each delivered pixel against the oldest one.
  class bc1_pixel_tracker;
    pixel_t pending_pixels[$];
    int     mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Channel expansion with the quotient truncated.
    function logic [7:0] widen5(logic [4:0] v);
      int unsigned p;
      p = (int'(v) * 255) / 31;
      return p[7:0];
    endfunction

    function logic [7:0] widen6(logic [5:0] v);
      int unsigned p;
      p = (int'(v) * 255) / 63;
      return p[7:0];
    endfunction

    function logic [31:0] opaque(int unsigned r, int unsigned g, int unsigned b);
      logic [7:0] r8, g8, b8;
      r8 = r[7:0];
      g8 = g[7:0];
      b8 = b[7:0];
      return {8'hFF, r8, g8, b8};
    endfunction

    // Builds the four-entry palette of a block and queues its sixteen pixels.
    function void note_block(logic [63:0] blk);
      logic [15:0]  c0, c1;
      logic [31:0]  idx;
      logic [31:0]  pal[4];
      int unsigned  r0, g0, b0, r1, g1, b1;
      logic [1:0]   sel;
      pixel_t       px;
      c0  = blk[15:0];
      c1  = blk[31:16];
      idx = blk[63:32];
      r0 = widen5(c0[15:11]);
      g0 = widen6(c0[10:5]);
      b0 = widen5(c0[4:0]);
      r1 = widen5(c1[15:11]);
      g1 = widen6(c1[10:5]);
      b1 = widen5(c1[4:0]);
      pal[0] = opaque(r0, g0, b0);
      pal[1] = opaque(r1, g1, b1);
      if (c0 > c1) begin
        pal[2] = opaque((2 * r0 + r1) / 3, (2 * g0 + g1) / 3, (2 * b0 + b1) / 3);
        pal[3] = opaque((r0 + 2 * r1) / 3, (g0 + 2 * g1) / 3, (b0 + 2 * b1) / 3);
      end else begin
        pal[2] = opaque((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2);
        pal[3] = 32'h0000_0000;
      end
      for (int i = 0; i < PixelsPerBlock; i++) begin
        sel       = idx[2 * i +: 2];
        px.argb   = pal[sel];
        px.column = i[1:0];
        px.row    = i[3:2];
        px.last   = (i == PixelsPerBlock - 1);
        pending_pixels.push_back(px);
      end
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel %08h with no pixel expected", got.argb));
      end else begin
        want = pending_pixels.pop_front();
        if (got.argb !== want.argb)
          report_mismatch($sformatf("argb %08h, expected %08h", got.argb, want.argb));
        if (got.column !== want.column)
          report_mismatch($sformatf("column %0d, expected %0d", got.column, want.column));
        if (got.row !== want.row)
          report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

  // Clock, reset and the block's ports. Every input is known from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [63:0] block_bits = 64'h0;
  logic        block_valid = 1'b0;
  logic        block_ready;
  logic        pixel_valid;
  logic        pixel_ready = 1'b0;
  logic [31:0] pixel_argb;
  logic [1:0]  pixel_column;
  logic [1:0]  pixel_row;
  logic        pixel_last;

  // Stretches without idling: while set, that side never waits.
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;

  bc1_pixel_tracker tracker = new();

  bc1_block_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .block_bits_i    (block_bits),
    .block_valid_i   (block_valid),
    .block_ready_o   (block_ready),
    .pixel_valid_o   (pixel_valid),
    .pixel_ready_i   (pixel_ready),
    .pixel_argb_o    (pixel_argb),
    .pixel_column_o  (pixel_column),
    .pixel_row_o     (pixel_row),
    .last_of_block_o (pixel_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offers one block after a random pause and holds it until the decoder
  // takes it. When there is no pause, valid simply stays high and only the
  // payload changes, so each signal sees a single assignment per edge.
  task send_block(logic [63:0] blk);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      block_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    block_bits  <= blk;
    block_valid <= 1'b1;
    // Signals read right after the edge still hold their pre-edge values.
    do @(posedge clk_i); while (!block_ready);
    tracker.note_block(blk);
  endtask

  // A random block whose color order is chosen: four-color mode, three-color
  // mode with equal endpoints, three-color mode with color0 below color1, or
  // a block of fully random bits.
  function logic [63:0] random_block();
    logic [15:0] a, b, t;
    int unsigned pick;
    a = 16'($urandom);
    b = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      return {$urandom, $urandom};
    end
    if (a == b) a = a ^ 16'h0001;
    if (a < b) begin
      t = a;
      a = b;
      b = t;
    end
    if (pick < 65) return {32'($urandom), b, a};   // color0 > color1
    if (pick < 78) return {32'($urandom), a, a};   // equal endpoints
    return {32'($urandom), a, b};                  // color0 < color1
  endfunction

  // Receiver: after a random pause it raises ready and takes one pixel.
  initial begin
    int gap;
    pixel_t got;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = take_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        pixel_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pixel_ready <= 1'b1;
      do @(posedge clk_i); while (!pixel_valid);
      got.argb   = pixel_argb;
      got.column = pixel_column;
      got.row    = pixel_row;
      got.last   = pixel_last;
      tracker.check_pixel(got);
    end
  end

  // Stimulus: directed blocks first, then random ones.
  initial begin
    logic [63:0] directed[$];
    directed = '{
      64'h0000_0000_0000_0000,   // all zero: equal endpoints, index 0
      64'hFFFF_FFFF_FFFF_FFFF,   // all ones: equal endpoints, transparent black
      64'h0000_0000_0000_FFFF,   // white over black, four colors, index 0
      64'h5555_5555_0000_FFFF,   // index 1 everywhere
      64'hAAAA_AAAA_0000_FFFF,   // first third everywhere
      64'hFFFF_FFFF_0000_FFFF,   // second third everywhere
      64'hE4E4_E4E4_0000_FFFF,   // every index in each row
      64'h1B1B_1B1B_FFFF_0000,   // three colors, color0 below color1
      64'hAAAA_AAAA_FFFF_0000,   // midpoint everywhere
      64'hFFFF_FFFF_FFFF_0000,   // transparent black everywhere
      64'hE4E4_E4E4_1234_1234,   // equal endpoints, mixed indices
      64'hFFFF_FFFF_8000_8000,   // equal endpoints, index 3
      64'hE4E4_E4E4_7FFF_8000,   // color0 one above color1
      64'hE4E4_E4E4_8000_7FFF,   // color0 one below color1
      64'hE4E4_E4E4_0000_F800,   // pure red over black
      64'hE4E4_E4E4_0000_07E0,   // pure green over black
      64'hE4E4_E4E4_0000_001F,   // pure blue over black
      64'hE4E4_E4E4_001F_07E0,   // green over blue
      64'h0123_4567_F81F_07E0,   // three colors, scattered indices
      64'hFEDC_BA98_07E0_F81F,   // four colors, scattered indices
      64'h3333_CCCC_0001_0000,   // smallest step above
      64'hC3C3_3C3C_FFFE_FFFF    // largest colors, four-color mode
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_block(directed[i]);
    for (int n = 0; n < 158; n++) begin
      // Switch now and then between idling and bursts on both sides.
      if (n % 30 == 0) begin
        send_burst = ($urandom_range(0, 2) == 0);
        take_burst = ($urandom_range(0, 2) == 0);
      end
      send_block(random_block());
    end
    block_valid <= 1'b0;
    send_burst = 1'b0;
    while (tracker.pending_pixels.size() != 0) @(posedge clk_i);
    // Keep the clock running so that any extra pixel would still show up.
    repeat (20) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
